>>> rtl/qpr_pkg.sv
// Types, constants and helper functions shared by the quaternion unit.
`timescale 1ns / 1ps

package qpr_pkg;

    localparam int WORD_BITS = 16;
    localparam int FRAC_BITS = 14;
    localparam int EXT_BITS  = WORD_BITS + 1;
    localparam int PROD_BITS = 2 * EXT_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int RND_BITS  = SUM_BITS - FRAC_BITS;

    typedef enum logic [1:0] {
        OP_PROD   = 2'd0,
        OP_ROTATE = 2'd1,
        OP_CONJ   = 2'd2,
        OP_SCALE  = 2'd3
    } opcode_t;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [EXT_BITS-1:0]  ext_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic signed [RND_BITS-1:0]  rnd_t;

    localparam rnd_t RND_WMAX = rnd_t'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam rnd_t RND_WMIN = rnd_t'(-(64'sd1 <<< (WORD_BITS - 1)));
    localparam rnd_t RND_IMAX = rnd_t'((64'sd1 <<< WORD_BITS) - 64'sd1);
    localparam rnd_t RND_IMIN = rnd_t'(-((64'sd1 <<< WORD_BITS) - 64'sd1));
    localparam sum_t SUM_HALF = sum_t'(64'sd1 <<< (FRAC_BITS - 1));

    // Four sums of four signed products each; index order x, y, z, w
    typedef struct packed {
        ext_t [3:0][3:0] lhs;
        ext_t [3:0][3:0] rhs;
        logic [3:0][3:0] neg;
    } terms_t;

    typedef struct packed {
        opcode_t      op;
        word_t [3:0]  a;
        rnd_t  [3:0]  res;
    } side_t;

    typedef struct packed {
        terms_t terms;
        side_t  side;
    } mul_req_t;

    typedef struct packed {
        prod_t [3:0][3:0] prod;
        side_t            side;
    } mul_rsp_t;

    typedef struct packed {
        rnd_t [3:0] rnd;
        side_t      side;
    } sum_rsp_t;

    typedef struct packed {
        word_t [3:0] r;
    } result_t;

    // Hamilton product p*q laid out as product terms
    function automatic terms_t ham_terms(input ext_t [3:0] p, input ext_t [3:0] q);
        terms_t t;
        t = '0;
        t.lhs[0][0] = p[3]; t.rhs[0][0] = q[0];
        t.lhs[0][1] = p[0]; t.rhs[0][1] = q[3];
        t.lhs[0][2] = p[1]; t.rhs[0][2] = q[2];
        t.lhs[0][3] = p[2]; t.rhs[0][3] = q[1]; t.neg[0][3] = 1'b1;

        t.lhs[1][0] = p[3]; t.rhs[1][0] = q[1];
        t.lhs[1][1] = p[0]; t.rhs[1][1] = q[2]; t.neg[1][1] = 1'b1;
        t.lhs[1][2] = p[1]; t.rhs[1][2] = q[3];
        t.lhs[1][3] = p[2]; t.rhs[1][3] = q[0];

        t.lhs[2][0] = p[3]; t.rhs[2][0] = q[2];
        t.lhs[2][1] = p[0]; t.rhs[2][1] = q[1];
        t.lhs[2][2] = p[1]; t.rhs[2][2] = q[0]; t.neg[2][2] = 1'b1;
        t.lhs[2][3] = p[2]; t.rhs[2][3] = q[3];

        t.lhs[3][0] = p[3]; t.rhs[3][0] = q[3];
        t.lhs[3][1] = p[0]; t.rhs[3][1] = q[0]; t.neg[3][1] = 1'b1;
        t.lhs[3][2] = p[1]; t.rhs[3][2] = q[1]; t.neg[3][2] = 1'b1;
        t.lhs[3][3] = p[2]; t.rhs[3][3] = q[2]; t.neg[3][3] = 1'b1;
        return t;
    endfunction

    // Each component times one scalar; remaining terms stay zero
    function automatic terms_t scale_terms(input ext_t [3:0] p, input ext_t s);
        terms_t t;
        t = '0;
        for (int i = 0; i < 4; i++)
        begin
            t.lhs[i][0] = p[i];
            t.rhs[i][0] = s;
        end
        return t;
    endfunction

    function automatic word_t sat_word(input rnd_t v);
        word_t w;
        if (v > RND_WMAX)
            w = word_t'(RND_WMAX);
        else if (v < RND_WMIN)
            w = word_t'(RND_WMIN);
        else
            w = word_t'(v);
        return w;
    endfunction

    // Symmetric clamp of the rotation intermediate
    function automatic ext_t clamp_ext(input rnd_t v);
        ext_t e;
        if (v > RND_IMAX)
            e = ext_t'(RND_IMAX);
        else if (v < RND_IMIN)
            e = ext_t'(RND_IMIN);
        else
            e = ext_t'(v);
        return e;
    endfunction

endpackage

>>> rtl/qpr_if.sv
// Request and response channel interfaces of the quaternion unit.
`timescale 1ns / 1ps

interface qpr_req_if;
    logic             valid;
    logic             ready;
    qpr_pkg::opcode_t opcode;
    qpr_pkg::word_t   a_x;
    qpr_pkg::word_t   a_y;
    qpr_pkg::word_t   a_z;
    qpr_pkg::word_t   a_w;
    qpr_pkg::word_t   b_x;
    qpr_pkg::word_t   b_y;
    qpr_pkg::word_t   b_z;
    qpr_pkg::word_t   b_w;
    qpr_pkg::word_t   scale;

    modport source (
        output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale,
        input  ready
    );
    modport sink (
        input  valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale,
        output ready
    );
endinterface

interface qpr_rsp_if;
    logic           valid;
    logic           ready;
    qpr_pkg::word_t r_x;
    qpr_pkg::word_t r_y;
    qpr_pkg::word_t r_z;
    qpr_pkg::word_t r_w;

    modport source (
        output valid, r_x, r_y, r_z, r_w,
        input  ready
    );
    modport sink (
        input  valid, r_x, r_y, r_z, r_w,
        output ready
    );
endinterface

>>> rtl/quaternion_product_rotate_unit.sv
// Top level of the fixed-point quaternion product and rotation unit.
//
//  channel | dir | word                                  | accepted when
//  req     | in  | opcode, a_x..a_w, b_x..b_w, scale     | req.valid && req.ready
//  rsp     | out | r_x, r_y, r_z, r_w                    | rsp.valid && rsp.ready
//
// Five register stages: multiply, sum, multiply, sum, output register.
// One word is accepted per cycle when rsp.ready stays high.
// The two multiply/sum pairs run the two Hamilton products of a rotation; other
// opcodes ride along and pick their result at the output register.
// Each stage holds its own valid bit; a stage advances when it is empty or the
// next one takes its word, so bubbles close up under a stall. Reset clears valids.
`timescale 1ns / 1ps

module quaternion_product_rotate_unit (
    input logic          clk,
    input logic          rst_n,
    qpr_req_if.sink      req,
    qpr_rsp_if.source    rsp
);
    import qpr_pkg::*;

    mul_req_t mul0_req;
    logic     mul0_valid;
    logic     mul0_ready;
    mul_rsp_t mul0_rsp;

    logic     sum0_valid;
    logic     sum0_ready;
    sum_rsp_t sum0_rsp;

    mul_req_t mul1_req;
    logic     mul1_valid;
    logic     mul1_ready;
    mul_rsp_t mul1_rsp;

    logic     sum1_valid;
    logic     sum1_ready;
    sum_rsp_t sum1_rsp;

    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_word_reg;
    result_t  out_word_next;

    // First product: A*B, A*(v,0) or A*scale
    always_comb
    begin
        ext_t [3:0] a_e;
        ext_t [3:0] b_e;
        a_e[0] = ext_t'(req.a_x);
        a_e[1] = ext_t'(req.a_y);
        a_e[2] = ext_t'(req.a_z);
        a_e[3] = ext_t'(req.a_w);
        b_e[0] = ext_t'(req.b_x);
        b_e[1] = ext_t'(req.b_y);
        b_e[2] = ext_t'(req.b_z);
        b_e[3] = (req.opcode == OP_ROTATE) ? '0 : ext_t'(req.b_w);

        if (req.opcode == OP_SCALE)
            mul0_req.terms = scale_terms(a_e, ext_t'(req.scale));
        else
            mul0_req.terms = ham_terms(a_e, b_e);

        mul0_req.side.op   = req.opcode;
        mul0_req.side.a[0] = req.a_x;
        mul0_req.side.a[1] = req.a_y;
        mul0_req.side.a[2] = req.a_z;
        mul0_req.side.a[3] = req.a_w;
        mul0_req.side.res  = '0;
    end

    assign req.ready = mul0_ready;

    qpr_mul u_mul0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (mul0_ready),
        .req_word  (mul0_req),
        .rsp_valid (mul0_valid),
        .rsp_ready (sum0_ready),
        .rsp_word  (mul0_rsp)
    );

    qpr_rsum u_sum0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (mul0_valid),
        .req_ready (sum0_ready),
        .req_word  (mul0_rsp),
        .rsp_valid (sum0_valid),
        .rsp_ready (mul1_ready),
        .rsp_word  (sum0_rsp)
    );

    // Second product: clamped intermediate times conj(A); keep first result aside
    always_comb
    begin
        ext_t [3:0] t_e;
        ext_t [3:0] c_e;
        for (int i = 0; i < 4; i++)
            t_e[i] = clamp_ext(sum0_rsp.rnd[i]);
        for (int i = 0; i < 3; i++)
            c_e[i] = -ext_t'($signed(sum0_rsp.side.a[i]));
        c_e[3] = ext_t'($signed(sum0_rsp.side.a[3]));

        mul1_req.terms    = ham_terms(t_e, c_e);
        mul1_req.side     = sum0_rsp.side;
        mul1_req.side.res = sum0_rsp.rnd;
    end

    assign mul1_valid = sum0_valid;

    qpr_mul u_mul1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (mul1_valid),
        .req_ready (mul1_ready),
        .req_word  (mul1_req),
        .rsp_valid (sum1_valid),
        .rsp_ready (sum1_ready),
        .rsp_word  (mul1_rsp)
    );

    logic     sum1_out_valid;
    logic     sum1_out_ready;

    qpr_rsum u_sum1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (sum1_valid),
        .req_ready (sum1_ready),
        .req_word  (mul1_rsp),
        .rsp_valid (sum1_out_valid),
        .rsp_ready (sum1_out_ready),
        .rsp_word  (sum1_rsp)
    );

    // Pick the result by opcode and saturate to the word range
    always_comb
    begin
        out_word_next = '0;
        case (sum1_rsp.side.op)
            OP_PROD, OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                    out_word_next.r[i] = sat_word(sum1_rsp.side.res[i]);
            end
            OP_ROTATE:
            begin
                for (int i = 0; i < 3; i++)
                    out_word_next.r[i] = sat_word(sum1_rsp.rnd[i]);
                out_word_next.r[3] = '0;
            end
            OP_CONJ:
            begin
                for (int i = 0; i < 3; i++)
                    out_word_next.r[i] = sat_word(-rnd_t'($signed(sum1_rsp.side.a[i])));
                out_word_next.r[3] = sum1_rsp.side.a[3];
            end
            default:
            begin
                out_word_next = '0;
            end
        endcase
    end

    assign sum1_out_ready = !out_valid_reg || rsp.ready;
    assign out_valid_next = sum1_out_ready ? sum1_out_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (sum1_out_ready && sum1_out_valid)
            out_word_reg <= out_word_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.r_x   = out_word_reg.r[0];
    assign rsp.r_y   = out_word_reg.r[1];
    assign rsp.r_z   = out_word_reg.r[2];
    assign rsp.r_w   = out_word_reg.r[3];

endmodule

>>> rtl/qpr_mul.sv
// Multiply stage: sixteen signed products, registered, with optional negation.
`timescale 1ns / 1ps

module qpr_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  qpr_pkg::mul_req_t req_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output qpr_pkg::mul_rsp_t rsp_word
);
    import qpr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    mul_rsp_t word_reg;
    mul_rsp_t word_next;

    assign req_ready = !valid_reg || rsp_ready;
    assign valid_next = req_ready ? req_valid : valid_reg;

    always_comb
    begin
        prod_t m;
        word_next.side = req_word.side;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                m = $signed(req_word.terms.lhs[i][j]) * $signed(req_word.terms.rhs[i][j]);
                word_next.prod[i][j] = req_word.terms.neg[i][j] ? -m : m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            word_reg <= word_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp_word  = word_reg;

endmodule

>>> rtl/qpr_rsum.sv
// Sum stage: adds four products per component and rounds half up.
`timescale 1ns / 1ps

module qpr_rsum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  qpr_pkg::mul_rsp_t req_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output qpr_pkg::sum_rsp_t rsp_word
);
    import qpr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    sum_rsp_t word_reg;
    sum_rsp_t word_next;

    assign req_ready = !valid_reg || rsp_ready;
    assign valid_next = req_ready ? req_valid : valid_reg;

    always_comb
    begin
        sum_t s;
        word_next.side = req_word.side;
        for (int i = 0; i < 4; i++)
        begin
            s = SUM_HALF;
            for (int j = 0; j < 4; j++)
                s = s + sum_t'($signed(req_word.prod[i][j]));
            // floor shift: drop the fraction bits
            word_next.rnd[i] = rnd_t'(s[SUM_BITS-1:FRAC_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            word_reg <= word_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp_word  = word_reg;

endmodule
